/* rtl/dep_pkg.sv */
// ----------------------------------------------------------------------------
// dep_pkg: shared types and constants for the double-ended priority queue
// Data width, opcode codes and the per-cycle control word sent to each cell.
// ----------------------------------------------------------------------------
`default_nettype none

package dep_pkg;

    localparam int DATA_W  = 32;
    localparam int OP_W    = 2;
    localparam int COUNT_W = 7;

    // Item opcodes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT     = 2'd0,
        OP_REMOVE_MAX = 2'd1,
        OP_REMOVE_MIN = 2'd2
    } op_t;

    // Control broadcast to every cell for one update
    typedef struct packed {
        logic insert;       // place the new value, shift larger ones up
        logic shift_down;   // every cell takes its upper neighbor's value; the top cell keeps its own
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/double_ended_priority_queue.sv */
// ----------------------------------------------------------------------------
// double_ended_priority_queue: bounded min/max queue of signed 32-bit values
// Sorted register chain with a fill counter and a registered result stage.
// ----------------------------------------------------------------------------
// Each item inserts a value (opcode 0), removes the maximum (1) or removes
// the minimum (2); every item yields one result with the new maximum,
// minimum, count, an empty flag and a rejected flag (insert into a full
// queue or removal from an empty one, which leave the queue unchanged).
// Max and min read 0 when empty; opcode 3 changes nothing. Values sit in
// ascending order in a chain of CAPACITY cells: an insert compares all cells
// in parallel and shifts the larger ones up, a minimum removal shifts the
// whole chain down, a maximum removal only lowers the count. An item first
// updates the chain; then the top entry is selected into the result register.
// The next item is taken only when no item waits for the result register and
// that register is free or is being read. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [dep_pkg::OP_W-1:0]          s_opcode,
    input  wire logic signed [dep_pkg::DATA_W-1:0] s_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [dep_pkg::DATA_W-1:0]      m_max_value,
    output logic signed [dep_pkg::DATA_W-1:0]      m_min_value,
    output logic [dep_pkg::COUNT_W-1:0]            m_count,
    output logic                                   m_is_empty,
    output logic                                   m_rejected
);
    import dep_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     pend_reg;
    logic                     rej_reg, rej_next;
    logic                     m_valid_reg;
    logic signed [DATA_W-1:0] max_reg, min_reg;
    logic [COUNT_W-1:0]       cnt_out_reg;
    logic                     empty_reg;
    logic                     rej_out_reg;

    logic                     accept;
    logic                     load_out;
    logic                     full;
    logic                     empty;
    cell_ctrl_t               ctrl;

    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    logic                     cell_gt   [CAPACITY];
    logic signed [DATA_W-1:0] top_tap   [CAPACITY];
    logic signed [DATA_W-1:0] top_value;

    assign full     = count_reg == CNT_W'(CAPACITY);
    assign empty    = count_reg == '0;
    assign s_ready  = !pend_reg && (!m_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign load_out = pend_reg && (!m_valid_reg || m_ready);

    // Decode the item into chain control, count update and rejected flag
    always_comb begin
        ctrl       = '0;
        count_next = count_reg;
        rej_next   = 1'b0;
        if (accept) begin
            unique case (s_opcode)
                OP_INSERT: begin
                    rej_next = full;
                    if (!full) begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                OP_REMOVE_MAX: begin
                    rej_next = empty;
                    if (!empty) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                OP_REMOVE_MIN: begin
                    rej_next = empty;
                    if (!empty) begin
                        ctrl.shift_down = 1'b1;
                        count_next      = count_reg - CNT_W'(1);
                    end
                end
                default: begin
                    rej_next = 1'b0;
                end
            endcase
        end
    end

    // Sorted cell chain
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DATA_W-1:0] lower_d;
        logic                     lower_g;
        logic signed [DATA_W-1:0] upper_d;

        if (i == 0) begin : g_first
            assign lower_d = s_value;
            assign lower_g = 1'b0;
        end else begin : g_mid
            assign lower_d = cell_data[i-1];
            assign lower_g = cell_gt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign upper_d = cell_data[i];
        end else begin : g_up
            assign upper_d = cell_data[i+1];
        end

        dep_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .new_value  (s_value),
            .count      (count_reg),
            .lower_data (lower_d),
            .lower_gt   (lower_g),
            .upper_data (upper_d),
            .data       (cell_data[i]),
            .gt         (cell_gt[i])
        );

        // Top entry tap: one-hot on the cell just below the count
        assign top_tap[i] = (CNT_W'(i + 1) == count_reg) ? cell_data[i] : '0;
    end

    // OR-reduce the one-hot taps into the current maximum
    always_comb begin
        top_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            top_value = top_value | top_tap[i];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                pend_reg <= 1'b1;
            end else if (load_out) begin
                pend_reg <= 1'b0;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            rej_reg <= rej_next;
        end
        if (load_out) begin
            max_reg     <= empty ? '0 : top_value;
            min_reg     <= empty ? '0 : cell_data[0];
            cnt_out_reg <= COUNT_W'(count_reg);
            empty_reg   <= empty;
            rej_out_reg <= rej_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_max_value = max_reg;
    assign m_min_value = min_reg;
    assign m_count     = cnt_out_reg;
    assign m_is_empty  = empty_reg;
    assign m_rejected  = rej_out_reg;

endmodule

`default_nettype wire

/* rtl/dep_cell.sv */
// ----------------------------------------------------------------------------
// dep_cell: one slot of the sorted register chain
// Holds one value, flags whether it is larger than the value being inserted,
// and takes a value from its lower or upper neighbor on an update.
// ----------------------------------------------------------------------------
`default_nettype none

module dep_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  wire logic                             aclk,
    input  wire dep_pkg::cell_ctrl_t              ctrl,
    input  wire logic signed [dep_pkg::DATA_W-1:0] new_value,
    input  wire logic [CNT_W-1:0]                 count,
    input  wire logic signed [dep_pkg::DATA_W-1:0] lower_data,
    input  wire logic                             lower_gt,
    input  wire logic signed [dep_pkg::DATA_W-1:0] upper_data,
    output logic signed [dep_pkg::DATA_W-1:0]     data,
    output logic                                  gt
);
    import dep_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     occupied;
    logic                     at_end;

    // Occupancy follows from the fill count; no per-cell valid bit
    assign occupied = CNT_W'(INDEX) < count;
    assign at_end   = CNT_W'(INDEX) == count;
    assign gt       = occupied && (data_reg > new_value);

    // Insert: cells above the new value move up one slot; the first such
    // cell (or the first free one) takes the new value
    always_comb begin
        data_next = data_reg;
        if (ctrl.insert && (gt || at_end)) begin
            data_next = lower_gt ? lower_data : new_value;
        end else if (ctrl.shift_down) begin
            data_next = upper_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* rtl/dep_checker.sv */
// ----------------------------------------------------------------------------
// dep_checker: port-level checks for the double-ended priority queue
// Watches the result channel for consistency of the reported fields.
// ----------------------------------------------------------------------------
`default_nettype none

module dep_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_ready,
    input  wire logic                              m_valid,
    input  wire logic                              m_ready,
    input  wire logic signed [dep_pkg::DATA_W-1:0] m_max_value,
    input  wire logic signed [dep_pkg::DATA_W-1:0] m_min_value,
    input  wire logic [dep_pkg::COUNT_W-1:0]       m_count,
    input  wire logic                              m_is_empty,
    input  wire logic                              m_rejected
);
    import dep_pkg::*;

    // Empty flag implies a zero count
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_empty) |-> (m_count == '0))
        else $error("is_empty disagrees with count");

    // Empty queue reports zero bounds
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_empty) |-> (m_max_value == '0 && m_min_value == '0))
        else $error("empty queue reports nonzero bounds");

    // Minimum never exceeds maximum
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_is_empty) |-> (m_min_value <= m_max_value))
        else $error("min above max");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_count)
            && $stable(m_max_value) && $stable(m_min_value)
            && $stable(m_is_empty) && $stable(m_rejected)))
        else $error("result changed while stalled");

    // A result waiting on the receiver blocks the input
    a_block_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while a result is stalled");

endmodule

bind double_ended_priority_queue dep_checker u_dep_checker (.*);

`default_nettype wire

/* sim/double_ended_priority_queue_test.sv */
// ----------------------------------------------------------------------------
// double_ended_priority_queue_test: self-checking bench for the min/max queue
// Drives insert, remove-max, remove-min and unused opcodes through the
// valid/ready input channel with random gaps and receiver stalls. A sorted
// shadow queue predicts max, min, count, empty and rejected for every item,
// and each result is checked in order against that prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_priority_queue_test;

    localparam int CAPACITY     = 64;
    localparam int TOTAL_ITEMS  = 1600;
    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS  = 40;

    // opcode value outside the enum; the block must ignore it
    localparam logic [dep_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic signed [31:0] max_value;
        logic signed [31:0] min_value;
        logic [6:0]         count;
        logic               is_empty;
        logic               rejected;
    } queue_status_t;

    typedef enum int {FILL_PHASE, DRAIN_PHASE, MIXED_PHASE} phase_t;

    // ------------------------------------------------------------------------
    // Shadow queue: ascending values plus the statuses still to come out
    // ------------------------------------------------------------------------
    class deque_scoreboard;
        logic signed [31:0] held[$];
        queue_status_t      pending_status[$];
        int errors;
        int items;
        int results;
        int full_hits;
        int empty_hits;
        int ignored;
        int peak;

        function void note_item(logic [dep_pkg::OP_W-1:0] op, logic signed [31:0] value);
            queue_status_t st;
            int pos;
            st.rejected = 1'b0;
            items++;
            case (op)
                dep_pkg::OP_INSERT: begin
                    if (held.size() >= CAPACITY) begin
                        st.rejected = 1'b1;
                        full_hits++;
                    end else begin
                        // equal values stay in arrival order
                        pos = 0;
                        while (pos < held.size() && held[pos] <= value) pos++;
                        held.insert(pos, value);
                    end
                end
                dep_pkg::OP_REMOVE_MAX: begin
                    if (held.size() == 0) begin
                        st.rejected = 1'b1;
                        empty_hits++;
                    end else begin
                        void'(held.pop_back());
                    end
                end
                dep_pkg::OP_REMOVE_MIN: begin
                    if (held.size() == 0) begin
                        st.rejected = 1'b1;
                        empty_hits++;
                    end else begin
                        void'(held.pop_front());
                    end
                end
                default: ignored++;
            endcase
            if (held.size() > peak) peak = held.size();
            if (held.size() > 0) begin
                st.max_value = held[$];
                st.min_value = held[0];
            end else begin
                st.max_value = '0;
                st.min_value = '0;
            end
            st.count    = 7'(held.size());
            st.is_empty = (held.size() == 0);
            pending_status.insert(pending_status.size(), st);
        endfunction

        function void compare_field(string name, logic signed [32:0] want,
                                    logic signed [32:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0d, got %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(queue_status_t got);
            queue_status_t want;
            results++;
            if (pending_status.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with nothing expected, got max %0d min %0d count %0d",
                             $time, got.max_value, got.min_value, got.count);
                return;
            end
            want = pending_status.pop_front();
            compare_field("max_value", 33'(want.max_value), 33'(got.max_value));
            compare_field("min_value", 33'(want.min_value), 33'(got.min_value));
            compare_field("count", 33'(want.count), 33'(got.count));
            compare_field("is_empty", 33'(want.is_empty), 33'(got.is_empty));
            compare_field("rejected", 33'(want.rejected), 33'(got.rejected));
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn   = 1'b0;
    logic                          s_valid   = 1'b0;
    logic                          s_ready;
    logic [dep_pkg::OP_W-1:0]      s_opcode  = '0;
    logic signed [31:0]            s_value   = '0;
    logic                          m_valid;
    logic                          m_ready   = 1'b0;
    logic signed [31:0]            m_max_value;
    logic signed [31:0]            m_min_value;
    logic [dep_pkg::COUNT_W-1:0]   m_count;
    logic                          m_is_empty;
    logic                          m_rejected;

    deque_scoreboard sb = new();

    int     sent;
    int     level;       // fill level as seen by the sender
    bit     steady_in;   // sender runs without gaps while set
    phase_t phase;

    double_ended_priority_queue #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_opcode   (s_opcode),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_max_value(m_max_value),
        .m_min_value(m_min_value),
        .m_count    (m_count),
        .m_is_empty (m_is_empty),
        .m_rejected (m_rejected)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // small values give duplicates, the rest spans the full range
    function automatic logic signed [31:0] pick_value();
        int r;
        int tmp;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            tmp = $urandom_range(0, 16);
            return tmp - 8;
        end
        if (r < 80) return $urandom;
        case ($urandom_range(0, 5))
            0: return VAL_MIN;
            1: return VAL_MIN + 1;
            2: return VAL_MAX;
            3: return VAL_MAX - 1;
            4: return -1;
            default: return 0;
        endcase
    endfunction

    // Present one item and hold it until the block takes it
    task automatic send_item(logic [dep_pkg::OP_W-1:0] op, logic signed [31:0] value);
        int gap;
        gap = steady_in ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_opcode <= op;
        s_value  <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
        if (op == dep_pkg::OP_INSERT) begin
            if (level < CAPACITY) level++;
        end else if (op != OP_UNUSED) begin
            if (level > 0) level--;
        end
    endtask

    // Receiver: bursts of ready with random stalls, sometimes no stalls at all
    initial begin
        bit steady_out;
        int stall;
        steady_out = 1'b0;
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, steady_out ? 200 : 6)) @(posedge aclk);
            stall = steady_out ? 0 : pick_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            if ($urandom_range(0, 20) == 0) steady_out = !steady_out;
        end
    end

    // Observe both channels at the clock edge
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_item(s_opcode, s_value);
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_max_value, m_min_value, m_count, m_is_empty, m_rejected});
    end

    // Watchdog: too long without any item moving on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // Stimulus
    initial begin
        logic [dep_pkg::OP_W-1:0] op;
        int insert_pct;
        int phase_left;
        int r;

        sent       = 0;
        level      = 0;
        steady_in  = 1'b0;
        phase      = FILL_PHASE;
        phase_left = 0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // removals and unused opcode on an empty queue
        send_item(dep_pkg::OP_REMOVE_MAX, 32'sh1234_5678);
        send_item(dep_pkg::OP_REMOVE_MIN, VAL_MIN);
        send_item(OP_UNUSED, VAL_MAX);
        // extremes and duplicates at both ends and in the middle
        send_item(dep_pkg::OP_INSERT, VAL_MAX);
        send_item(dep_pkg::OP_INSERT, VAL_MIN);
        send_item(dep_pkg::OP_INSERT, 0);
        send_item(dep_pkg::OP_INSERT, -1);
        send_item(dep_pkg::OP_INSERT, 5);
        send_item(dep_pkg::OP_INSERT, 5);
        send_item(dep_pkg::OP_INSERT, VAL_MIN);
        send_item(dep_pkg::OP_INSERT, VAL_MAX);
        send_item(OP_UNUSED, 32'sh5555_aaaa);
        // drain from alternating ends, then one removal too many
        repeat (4) begin
            send_item(dep_pkg::OP_REMOVE_MAX, 32'shaaaa_5555);
            send_item(dep_pkg::OP_REMOVE_MIN, 32'sh0f0f_f0f0);
        end
        send_item(dep_pkg::OP_REMOVE_MIN, 0);

        // Random part: fill to full, drain to empty, or wander in between
        while (sent < TOTAL_ITEMS) begin
            case (phase)
                FILL_PHASE:  insert_pct = 85;
                DRAIN_PHASE: insert_pct = 15;
                default:     insert_pct = 50;
            endcase
            r = $urandom_range(0, 99);
            if (r < 3)
                op = OP_UNUSED;
            else if (r < insert_pct)
                op = dep_pkg::OP_INSERT;
            else if ($urandom_range(0, 1) == 0)
                op = dep_pkg::OP_REMOVE_MAX;
            else
                op = dep_pkg::OP_REMOVE_MIN;
            send_item(op, pick_value());

            case (phase)
                FILL_PHASE: begin
                    if (level == CAPACITY && $urandom_range(0, 3) == 0)
                        phase = ($urandom_range(0, 2) == 0) ? MIXED_PHASE : DRAIN_PHASE;
                end
                DRAIN_PHASE: begin
                    if (level == 0 && $urandom_range(0, 3) == 0)
                        phase = ($urandom_range(0, 2) == 0) ? MIXED_PHASE : FILL_PHASE;
                end
                default: begin
                    if (phase_left <= 0) begin
                        phase = ($urandom_range(0, 1) == 0) ? FILL_PHASE : DRAIN_PHASE;
                        phase_left = $urandom_range(50, 150);
                    end else begin
                        phase_left--;
                    end
                end
            endcase
            if ($urandom_range(0, 99) == 0) steady_in = !steady_in;
        end
        s_valid <= 1'b0;

        // let every result come out, then let the bench settle
        while (sb.results < sent) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d items and %0d results, peak fill %0d of %0d.",
                 sb.items, sb.results, sb.peak, CAPACITY);
        $display("Inserts into a full queue: %0d, removals from empty: %0d,",
                 sb.full_hits, sb.empty_hits);
        $display("unused ops: %0d, errors: %0d.", sb.ignored, sb.errors);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
